@@ hw/rtl/mae_pkg.sv @@
package mae_pkg;

    // Row and column indexes are three bits wide on every interface.
    localparam int IDX_W = 3;
    localparam int SUM_W = 32;

    localparam logic [1:0] OP_LOAD_A  = 2'd0;
    localparam logic [1:0] OP_LOAD_B  = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_ROWS_A = 3'd1;
    localparam logic [2:0] REG_COLS_A = 3'd2;
    localparam logic [2:0] REG_ROWS_B = 3'd3;
    localparam logic [2:0] REG_COLS_B = 3'd4;

    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_MUL = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Control part of a token that walks down the row of cells.
    typedef struct packed {
        logic             v;
        logic             first;
        logic [IDX_W-1:0] k;
        logic [IDX_W-1:0] i;
    } t_tok;

endpackage

@@ hw/rtl/mae_ram.sv @@
module mae_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/mae_cell.sv @@
module mae_cell
    import mae_pkg::*;
#(
    parameter int MAX_DIM   = 8,
    parameter int ELEM_BITS = 16,
    parameter int COL       = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_mode,
    input  logic                 i_wr_en,
    input  logic [IDX_W-1:0]     i_wr_row,
    input  logic [ELEM_BITS-1:0] i_wr_data,
    input  t_tok                 i_tok,
    input  logic [ELEM_BITS-1:0] i_a,
    output t_tok                 o_tok,
    output logic [ELEM_BITS-1:0] o_a,
    output logic [SUM_W-1:0]     o_acc
);

    localparam int BW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    // Column COL of matrix B, indexed by row.
    logic [ELEM_BITS-1:0] r_b [MAX_DIM];

    t_tok                 r_tok;
    logic [ELEM_BITS-1:0] r_a;
    logic                 r_t_v;
    logic                 r_t_first;
    logic [SUM_W-1:0]     r_term;
    logic [SUM_W-1:0]     r_acc;

    logic [IDX_W-1:0]             w_addr;
    logic signed [ELEM_BITS-1:0]  w_a;
    logic signed [ELEM_BITS-1:0]  w_b;
    logic signed [2*ELEM_BITS-1:0] w_prod;
    logic signed [SUM_W-1:0]      w_sum;
    logic [SUM_W-1:0]             n_term;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_b[i_wr_row[BW-1:0]] <= i_wr_data;
        end
    end

    // A product reads row k of this column, a sum reads row i.
    assign w_addr = (i_mode == MODE_MUL) ? i_tok.k : i_tok.i;
    assign w_a    = i_a;
    assign w_b    = r_b[w_addr[BW-1:0]];
    assign w_prod = w_a * w_b;
    assign w_sum  = SUM_W'(w_a) + SUM_W'(w_b);

    always_comb begin
        if (i_mode == MODE_MUL) begin
            n_term = SUM_W'(w_prod);
        end else if (i_tok.k == IDX_W'(COL)) begin
            n_term = w_sum;
        end else begin
            n_term = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.v <= 1'b0;
            r_t_v   <= 1'b0;
        end else begin
            r_tok.v <= i_tok.v;
            r_t_v   <= i_tok.v;
        end
        r_tok.first <= i_tok.first;
        r_tok.k     <= i_tok.k;
        r_tok.i     <= i_tok.i;
        r_a         <= i_a;
        r_t_first   <= i_tok.first;
        r_term      <= n_term;
        if (r_t_v) begin
            r_acc <= (r_t_first ? '0 : r_acc) + r_term;
        end
    end

    assign o_tok = r_tok;
    assign o_a   = r_a;
    assign o_acc = r_acc;

endmodule

@@ hw/rtl/matrix_add_multiply_engine_core.sv @@
// Integer matrix add and multiply engine.
// Input stream: tuser carries the operation (load A, load B, compute), tdata
// carries row, column and the element value. Loads write one element per
// cycle while idle and while no result waits on a stalled receiver.
// Configuration (mode and the four dimensions) goes through the cfg write
// channel, which is always ready, and must be written only while idle; the
// block itself does not enforce this. A compute transfer produces the result
// elements row by row on the output stream, tlast on the final one; tuser is
// the status bit, and a shape mismatch or a dimension out of range gives one
// error transfer with status set and tlast high. Matrix B lives in a row of
// MAX_DIM cells, one per result column; A sits in a memory. For each result
// row, cols_a elements of A are read one a cycle and pass down the cell row,
// each cell accumulating its own column. After feeding, the row settles in a
// wait state and its results are then emitted. No new input is taken until a
// compute has emitted all of its results. A stalled receiver holds the
// output register and the sequence pauses. Reset clears configuration to add
// mode with 1x1 shapes and leaves matrix contents undefined.
module matrix_add_multiply_engine_core
    import mae_pkg::*;
#(
    parameter int MAX_DIM   = 8,
    parameter int ELEM_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // row[2:0], col[5:3], value[21:6]
    input  logic [1:0]  i_s_axis_tuser,  // op[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,  // out_row[2:0], out_col[5:3], sum[37:6]
    output logic        o_m_axis_tuser,  // status[0]
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int WAIT_N = MAX_DIM + 3;
    localparam int WW     = $clog2(WAIT_N + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_FEED = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic       r_mode;
    logic [3:0] r_rows_a;
    logic [3:0] r_cols_a;
    logic [3:0] r_rows_b;
    logic [3:0] r_cols_b;

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_k, n_k;
    logic [IDX_W-1:0] r_j, n_j;
    logic [WW-1:0]    r_wait, n_wait;
    logic             r_rd_v, n_rd_v;
    logic [IDX_W-1:0] r_rd_k, n_rd_k;

    logic             r_o_valid, n_o_valid;
    logic             r_o_status, n_o_status;
    logic [IDX_W-1:0] r_o_row, n_o_row;
    logic [IDX_W-1:0] r_o_col, n_o_col;
    logic [SUM_W-1:0] r_o_sum, n_o_sum;
    logic             r_o_last, n_o_last;

    logic [1:0]           w_op;
    logic [IDX_W-1:0]     w_row;
    logic [IDX_W-1:0]     w_col;
    logic signed [15:0]   w_value;
    logic [ELEM_BITS-1:0] w_elem;
    logic                 w_s_acc;
    logic                 w_in_range;
    logic                 w_dims_ok;
    logic [3:0]           w_nc;
    logic                 w_col_last;
    logic                 w_row_last;
    logic [AW-1:0]        w_waddr;
    logic [AW-1:0]        w_raddr;
    logic [ELEM_BITS-1:0] w_ram_q;

    t_tok                 w_tok [MAX_DIM+1];
    logic [ELEM_BITS-1:0] w_a   [MAX_DIM+1];
    logic [SUM_W-1:0]     w_acc [MAX_DIM];

    function automatic logic dim_ok(input logic [3:0] d);
        return (d != 4'd0) && (32'(d) <= MAX_DIM);
    endfunction

    assign w_op    = i_s_axis_tuser;
    assign w_row   = i_s_axis_tdata[2:0];
    assign w_col   = i_s_axis_tdata[5:3];
    assign w_value = i_s_axis_tdata[21:6];
    assign w_elem  = ELEM_BITS'(w_value);

    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_o_valid || i_m_axis_tready);
    assign w_s_acc         = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_range      = (32'(w_row) < MAX_DIM) && (32'(w_col) < MAX_DIM);

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_ADD;
            r_rows_a <= 4'd1;
            r_cols_a <= 4'd1;
            r_rows_b <= 4'd1;
            r_cols_b <= 4'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MODE:   r_mode   <= i_cfg_data[0];
                REG_ROWS_A: r_rows_a <= i_cfg_data;
                REG_COLS_A: r_cols_a <= i_cfg_data;
                REG_ROWS_B: r_rows_b <= i_cfg_data;
                REG_COLS_B: r_cols_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_mode == MODE_MUL) begin
            w_dims_ok = dim_ok(r_rows_a) && dim_ok(r_cols_a) && dim_ok(r_cols_b)
                        && (r_cols_a == r_rows_b);
        end else begin
            w_dims_ok = dim_ok(r_rows_a) && dim_ok(r_cols_a)
                        && (r_rows_a == r_rows_b) && (r_cols_a == r_cols_b);
        end
    end

    assign w_nc       = (r_mode == MODE_MUL) ? r_cols_b : r_cols_a;
    assign w_col_last = ({1'b0, r_j} + 4'd1) == w_nc;
    assign w_row_last = ({1'b0, r_i} + 4'd1) == r_rows_a;

    assign w_waddr = AW'(32'(w_row) * MAX_DIM + 32'(w_col));
    assign w_raddr = AW'(32'(r_i) * MAX_DIM + 32'(r_k));

    mae_ram #(
        .WIDTH (ELEM_BITS),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_we    (w_s_acc && (w_op == OP_LOAD_A) && w_in_range),
        .i_waddr (w_waddr),
        .i_wdata (w_elem),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    // The memory output is registered and arrives together with r_rd_v and r_rd_k.
    assign w_tok[0].v     = r_rd_v;
    assign w_tok[0].first = (r_rd_k == '0);
    assign w_tok[0].k     = r_rd_k;
    assign w_tok[0].i     = r_i;
    assign w_a[0]         = w_ram_q;

    for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
        mae_cell #(
            .MAX_DIM   (MAX_DIM),
            .ELEM_BITS (ELEM_BITS),
            .COL       (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_mode    (r_mode),
            .i_wr_en   (w_s_acc && (w_op == OP_LOAD_B) && w_in_range
                        && (w_col == IDX_W'(g))),
            .i_wr_row  (w_row),
            .i_wr_data (w_elem),
            .i_tok     (w_tok[g]),
            .i_a       (w_a[g]),
            .o_tok     (w_tok[g+1]),
            .o_a       (w_a[g+1]),
            .o_acc     (w_acc[g])
        );
    end

    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_k        = r_k;
        n_j        = r_j;
        n_wait     = r_wait;
        n_rd_v     = 1'b0;
        n_rd_k     = r_k;
        n_o_valid  = r_o_valid && !i_m_axis_tready;
        n_o_status = r_o_status;
        n_o_row    = r_o_row;
        n_o_col    = r_o_col;
        n_o_sum    = r_o_sum;
        n_o_last   = r_o_last;
        unique case (r_state)
            S_IDLE: begin
                if (w_s_acc && (w_op == OP_COMPUTE)) begin
                    if (!w_dims_ok) begin
                        n_o_valid  = 1'b1;
                        n_o_status = STATUS_ERR;
                        n_o_row    = '0;
                        n_o_col    = '0;
                        n_o_sum    = '0;
                        n_o_last   = 1'b1;
                    end else begin
                        n_state = S_FEED;
                        n_i     = '0;
                        n_k     = '0;
                    end
                end
            end
            S_FEED: begin
                n_rd_v = 1'b1;
                if (({1'b0, r_k} + 4'd1) == r_cols_a) begin
                    n_state = S_WAIT;
                    n_wait  = '0;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_WAIT: begin
                n_wait = r_wait + 1'b1;
                if (r_wait == WW'(WAIT_N - 1)) begin
                    n_state = S_EMIT;
                    n_j     = '0;
                end
            end
            S_EMIT: begin
                if (!r_o_valid || i_m_axis_tready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = STATUS_OK;
                    n_o_row    = r_i;
                    n_o_col    = r_j;
                    n_o_sum    = w_acc[r_j[BW-1:0]];
                    n_o_last   = w_row_last && w_col_last;
                    if (w_col_last) begin
                        if (w_row_last) begin
                            n_state = S_IDLE;
                        end else begin
                            n_i     = r_i + 1'b1;
                            n_k     = '0;
                            n_state = S_FEED;
                        end
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_i       <= '0;
            r_k       <= '0;
            r_j       <= '0;
            r_wait    <= '0;
            r_rd_v    <= 1'b0;
            r_rd_k    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_i       <= n_i;
            r_k       <= n_k;
            r_j       <= n_j;
            r_wait    <= n_wait;
            r_rd_v    <= n_rd_v;
            r_rd_k    <= n_rd_k;
            r_o_valid <= n_o_valid;
        end
        r_o_status <= n_o_status;
        r_o_row    <= n_o_row;
        r_o_col    <= n_o_col;
        r_o_sum    <= n_o_sum;
        r_o_last   <= n_o_last;
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {2'b00, r_o_sum, r_o_col, r_o_row};
    assign o_m_axis_tuser  = r_o_status;
    assign o_m_axis_tlast  = r_o_last;

`ifndef ASSERT_OFF
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_o_status == STATUS_ERR)) |-> r_o_last)
        else $error("error transfer without tlast");

    a_emit_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> ({1'b0, r_j} < w_nc))
        else $error("emit column beyond result width");

    a_last_at_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_last && (r_o_status == STATUS_OK))
        |-> (({1'b0, r_o_row} + 4'd1) == r_rows_a)
            && (({1'b0, r_o_col} + 4'd1) == w_nc))
        else $error("tlast on an element that is not the final one");

    a_no_feed_while_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_s_axis_tready)
        else $error("input taken during a compute");
`endif

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import mae_pkg::*;

    localparam int DIM = 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 60;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    typedef struct {
        logic        status;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] sum;
        logic        last;
    } t_elem_result;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [3:0]  cfg_data = '0;

    matrix_add_multiply_engine_core dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tuser (m_tuser),
        .o_m_axis_tlast (m_tlast),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Shadow copy of the engine: configuration, both matrices and write flags.
    logic              shadow_mode = MODE_ADD;
    logic [3:0]        shadow_rows_a = 4'd1;
    logic [3:0]        shadow_cols_a = 4'd1;
    logic [3:0]        shadow_rows_b = 4'd1;
    logic [3:0]        shadow_cols_b = 4'd1;
    logic signed [15:0] a_elems [DIM*DIM];
    logic signed [15:0] b_elems [DIM*DIM];
    bit                a_loaded [DIM*DIM];
    bit                b_loaded [DIM*DIM];

    t_elem_result pending_results[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int error_count = 0;
    int items_sent = 0;
    int results_seen = 0;
    int computes_sent = 0;
    int error_computes = 0;
    int cycle_count = 0;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[matrix_add_multiply_engine_core] ERROR");
            $finish;
        end
    end

    // Receiver side: random stalls, plus a counted hold-off when requested.
    always @(negedge clk) begin
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else begin
            m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        t_elem_result exp_r;
        if (rst_n && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result tdata=%h tuser=%b tlast=%b",
                         $time, m_tdata, m_tuser, m_tlast);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_tuser !== exp_r.status || m_tdata[2:0] !== exp_r.row ||
                    m_tdata[5:3] !== exp_r.col || m_tdata[37:6] !== exp_r.sum ||
                    m_tlast !== exp_r.last) begin
                    $display("%0t: mismatch expected st=%b r=%0d c=%0d sum=%h last=%b",
                             $time, exp_r.status, exp_r.row, exp_r.col, exp_r.sum,
                             exp_r.last);
                    $display("%0t:          actual   st=%b r=%0d c=%0d sum=%h last=%b",
                             $time, m_tuser, m_tdata[2:0], m_tdata[5:3], m_tdata[37:6],
                             m_tlast);
                    error_count++;
                end
            end
        end
    end

    function automatic bit dim_valid(logic [3:0] d);
        return d >= 1 && d <= DIM;
    endfunction

    // True when a compute under the current setting reads the matrices.
    function automatic bit shape_valid();
        if (shadow_mode == MODE_ADD)
            return dim_valid(shadow_rows_a) && dim_valid(shadow_cols_a) &&
                   shadow_rows_a == shadow_rows_b && shadow_cols_a == shadow_cols_b;
        return dim_valid(shadow_rows_a) && dim_valid(shadow_cols_a) &&
               dim_valid(shadow_cols_b) && shadow_cols_a == shadow_rows_b;
    endfunction

    function automatic void push_result(logic status, int r, int c, logic [31:0] s,
                                        logic last);
        t_elem_result res;
        res.status = status;
        res.row = r[2:0];
        res.col = c[2:0];
        res.sum = s;
        res.last = last;
        pending_results.push_back(res);
    endfunction

    function automatic void predict_compute();
        int nr;
        int nc;
        int acc;
        computes_sent++;
        if (!shape_valid()) begin
            error_computes++;
            push_result(STATUS_ERR, 0, 0, 32'd0, 1'b1);
            return;
        end
        nr = int'(shadow_rows_a);
        nc = int'((shadow_mode == MODE_ADD) ? shadow_cols_a : shadow_cols_b);
        for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
                if (shadow_mode == MODE_ADD) begin
                    acc = int'(a_elems[i*DIM+j]) + int'(b_elems[i*DIM+j]);
                end else begin
                    acc = 0;
                    for (int k = 0; k < shadow_cols_a; k++)
                        acc += int'(a_elems[i*DIM+k]) * int'(b_elems[k*DIM+j]);
                end
                push_result(STATUS_OK, i, j, acc, (i == nr - 1) && (j == nc - 1));
            end
        end
    endfunction

    function automatic void predict_item(logic [1:0] op, logic [2:0] r, logic [2:0] c,
                                         logic [15:0] v);
        case (op)
            OP_LOAD_A: begin
                a_elems[r*DIM+c] = v;
                a_loaded[r*DIM+c] = 1'b1;
            end
            OP_LOAD_B: begin
                b_elems[r*DIM+c] = v;
                b_loaded[r*DIM+c] = 1'b1;
            end
            OP_COMPUTE: predict_compute();
            default: ;
        endcase
    endfunction

    task automatic send_item(logic [1:0] op, logic [2:0] r, logic [2:0] c,
                             logic [15:0] v);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = op;
        s_tdata = {2'b00, v, c, r};
        do @(posedge clk); while (!s_tready);
        items_sent++;
        predict_item(op, r, c, v);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // Waits for every expected result, then lets trailing loads settle.
    task automatic drain();
        stop_sending();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [3:0] d);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = d;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_MODE:   shadow_mode = d[0];
            REG_ROWS_A: shadow_rows_a = d;
            REG_COLS_A: shadow_cols_a = d;
            REG_ROWS_B: shadow_rows_b = d;
            REG_COLS_B: shadow_cols_b = d;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_shape(logic m, logic [3:0] ra, logic [3:0] ca, logic [3:0] rb,
                             logic [3:0] cb);
        write_reg(REG_MODE, {3'b000, m});
        write_reg(REG_ROWS_A, ra);
        write_reg(REG_COLS_A, ca);
        write_reg(REG_ROWS_B, rb);
        write_reg(REG_COLS_B, cb);
    endtask

    // Loads every element the next compute reads that was never written.
    task automatic load_missing();
        int rb;
        int cb;
        if (!shape_valid())
            return;
        rb = int'((shadow_mode == MODE_ADD) ? shadow_rows_a : shadow_cols_a);
        cb = int'((shadow_mode == MODE_ADD) ? shadow_cols_a : shadow_cols_b);
        for (int i = 0; i < shadow_rows_a; i++)
            for (int j = 0; j < shadow_cols_a; j++)
                if (!a_loaded[i*DIM+j])
                    send_item(OP_LOAD_A, i[2:0], j[2:0], 16'($urandom));
        for (int i = 0; i < rb; i++)
            for (int j = 0; j < cb; j++)
                if (!b_loaded[i*DIM+j])
                    send_item(OP_LOAD_B, i[2:0], j[2:0], 16'($urandom));
    endtask

    task automatic test_reset_shape();
        send_item(OP_LOAD_A, 3'd0, 3'd0, 16'sh7fff);
        send_item(OP_LOAD_B, 3'd0, 3'd0, 16'sh7fff);
        send_item(OP_COMPUTE, 3'd0, 3'd0, 16'h0000);
        drain();
    endtask

    task automatic test_extremes();
        write_reg(REG_SPARE_LO, 4'hf);
        write_reg(REG_SPARE_HI, 4'h0);
        send_item(OP_LOAD_A, 3'd0, 3'd0, 16'sh8000);
        send_item(OP_LOAD_B, 3'd0, 3'd0, 16'sh8000);
        send_item(OP_UNUSED, 3'd7, 3'd7, 16'hffff);
        send_item(OP_COMPUTE, 3'd7, 3'd7, 16'hffff);
        drain();
        // A row of -32768 times a column of -32768 sums eight 2^30 terms and wraps.
        set_shape(MODE_MUL, 4'd1, 4'd8, 4'd8, 4'd1);
        for (int k = 0; k < DIM; k++) begin
            send_item(OP_LOAD_A, 3'd0, k[2:0], 16'sh8000);
            send_item(OP_LOAD_B, k[2:0], 3'd0, 16'sh8000);
        end
        send_item(OP_COMPUTE, 3'd0, 3'd0, 16'h0000);
        drain();
    endtask

    task automatic test_shape_errors();
        set_shape(MODE_ADD, 4'd2, 4'd3, 4'd3, 4'd2);
        send_item(OP_COMPUTE, 3'd0, 3'd0, 16'h0000);
        drain();
        set_shape(MODE_MUL, 4'd2, 4'd3, 4'd2, 4'd2);
        send_item(OP_COMPUTE, 3'd0, 3'd0, 16'h0000);
        drain();
        set_shape(MODE_ADD, 4'd0, 4'd0, 4'd0, 4'd0);
        send_item(OP_COMPUTE, 3'd0, 3'd0, 16'h0000);
        drain();
        set_shape(MODE_MUL, 4'd9, 4'd15, 4'd15, 4'd12);
        send_item(OP_COMPUTE, 3'd0, 3'd0, 16'h0000);
        drain();
        set_shape(MODE_MUL, 4'd1, 4'd1, 4'd1, 4'd0);
        send_item(OP_COMPUTE, 3'd0, 3'd0, 16'h0000);
        drain();
    endtask

    task automatic random_setting(bit full_size);
        logic m;
        logic [3:0] ra;
        logic [3:0] ca;
        logic [3:0] rb;
        logic [3:0] cb;
        int n_loads;
        int pick;
        m = 1'($urandom_range(0, 1));
        ra = full_size ? 4'd8 : 4'($urandom_range(1, 3));
        ca = full_size ? 4'd8 : 4'($urandom_range(1, 3));
        cb = full_size ? 4'd8 : 4'($urandom_range(1, 3));
        rb = (m == MODE_ADD) ? ra : ca;
        if (m == MODE_ADD)
            cb = ca;
        // Now and then break the shape or push a dimension out of range.
        if (!full_size && $urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
                0: rb = rb + 4'd1;
                1: cb = 4'($urandom_range(9, 15));
                default: ra = 4'd0;
            endcase
        end
        set_shape(m, ra, ca, rb, cb);
        n_loads = $urandom_range(2, 10);
        for (int n = 0; n < n_loads; n++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                send_item(OP_UNUSED, 3'($urandom), 3'($urandom), 16'($urandom));
            else
                send_item(pick < 6 ? OP_LOAD_A : OP_LOAD_B, 3'($urandom), 3'($urandom),
                          16'($urandom));
        end
        load_missing();
        send_item(OP_COMPUTE, 3'($urandom), 3'($urandom), 16'($urandom));
        drain();
    endtask

    task automatic test_random_traffic();
        int target;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            target = items_sent + 45;
            if (phase == 1)
                random_setting(1'b1);
            while (items_sent < target)
                random_setting(1'b0);
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    // Long receiver hold-off while input keeps coming, so the engine backs up.
    task automatic test_backpressure();
        set_shape(MODE_MUL, 4'd2, 4'd2, 4'd2, 4'd2);
        load_missing();
        hold_left = 400;
        send_item(OP_COMPUTE, 3'd0, 3'd0, 16'h0000);
        for (int n = 0; n < 6; n++)
            send_item(OP_LOAD_A, 3'($urandom_range(0, 1)), 3'($urandom_range(0, 1)),
                      16'($urandom));
        send_item(OP_COMPUTE, 3'd0, 3'd0, 16'h0000);
        drain();
    endtask

    initial begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        test_reset_shape();
        test_extremes();
        test_shape_errors();
        test_random_traffic();
        test_backpressure();
        $display("Sent %0d items with %0d computes (%0d shape errors); checked %0d results.",
                 items_sent, computes_sent, error_computes, results_seen);
        if (error_count == 0)
            $display("[matrix_add_multiply_engine_core] OK");
        else
            $display("[matrix_add_multiply_engine_core] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/mae_pkg.sv
hw/rtl/mae_ram.sv
hw/rtl/mae_cell.sv
hw/rtl/matrix_add_multiply_engine_core.sv
bench/tb.sv
